>>> hdl/swrl_pkg.sv
// Package for the sliding-window rate limiter: payload structs and fixed constants.
// Depends on nothing; used by every module of the block but swrl_ram.
package swrl_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  localparam int LimitW = 8;
  localparam int TimeW = 32;

  localparam int NUM_GROUPS = 4;
  localparam int NUM_KEYS = 16;
  localparam int MAX_SLOTS = 128;
  localparam int NUM_FLOWS = NUM_GROUPS * NUM_KEYS;
  localparam int FLOW_W = $clog2(NUM_FLOWS);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W = FLOW_W + SLOT_W;

  localparam logic [CfgIdxW-1:0] REG_MAX_REQ_0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_0 = 3'd4;

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic        action;
    logic [2:0]  group;
    logic [3:0]  key_id;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic        allowed;
    logic [31:0] retry_after;
  } out_item_t;

  // Work handed from the front part to the back part.
  typedef struct packed {
    logic        no_rule;
    logic        action;
    logic [1:0]  group;
    logic [3:0]  key_id;
    logic [31:0] now;
  } job_t;

  // Per-flow ring bookkeeping kept in the ring memory.
  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [CNT_W-1:0]  count;
  } ring_t;

endpackage

>>> hdl/swrl_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module swrl_ram #(
  parameter int Width = 32,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> hdl/swrl_front.sv
// Front part: accepts input transactions and classifies them into jobs.
// Depends on swrl_pkg.
module swrl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swrl_pkg::in_item_t in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output swrl_pkg::job_t    job
);
  // Two-entry queue between front and back.
  swrl_pkg::job_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r;
  swrl_pkg::job_t new_job;
  logic push, pop;

  always_comb begin
    new_job.no_rule = ({29'd0, in_data.group} >= swrl_pkg::NUM_GROUPS);
    new_job.action  = in_data.action;
    new_job.group   = in_data.group[1:0];
    new_job.key_id  = in_data.key_id;
    new_job.now     = in_data.now;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_r];
  assign pop       = job_valid && job_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt  = rd_r ^ pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      if (push) begin
        wr_r <= ~wr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= new_job;
    end
  end
endmodule

>>> hdl/swrl_back.sv
// Back part: runs one job at a time against the flow's stamp ring.
// Depends on swrl_pkg and swrl_ram.
module swrl_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  swrl_pkg::job_t        job,
  output logic                  out_valid,
  input  logic                  out_ready,
  output swrl_pkg::out_item_t   out_data
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_META  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EVAL  = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [7:0]  maxr_r [swrl_pkg::NUM_GROUPS];
  logic [31:0] win_r  [swrl_pkg::NUM_GROUPS];
  swrl_pkg::job_t   job_r;
  logic [swrl_pkg::FLOW_W-1:0] flow;
  logic [swrl_pkg::FLOW_W-1:0] clr_r;
  logic [swrl_pkg::SLOT_W-1:0] head_r;
  logic [swrl_pkg::CNT_W-1:0]  cnt_r;
  logic [31:0] win, age;
  logic [swrl_pkg::CNT_W-1:0] limit;
  logic [7:0] lim8;
  logic evict, allow;
  logic [swrl_pkg::SLOT_W-1:0] pos;
  logic stamp_we;
  logic [swrl_pkg::ADDR_W-1:0] stamp_addr;
  logic [31:0] stamp_rd;
  logic meta_we;
  logic [swrl_pkg::FLOW_W-1:0] meta_addr;
  swrl_pkg::ring_t meta_wdata, meta_rd;
  swrl_pkg::out_item_t res_w_r, res_r;
  logic        ov_r;
  logic        out_load;

  assign flow  = {job_r.group, job_r.key_id};
  assign win   = win_r[job_r.group];
  assign lim8  = maxr_r[job_r.group];
  assign limit = ({24'd0, lim8} > swrl_pkg::MAX_SLOTS) ?
                 swrl_pkg::CNT_W'(swrl_pkg::MAX_SLOTS) : swrl_pkg::CNT_W'(lim8);
  assign age   = job_r.now - stamp_rd;
  assign pos   = head_r + cnt_r[swrl_pkg::SLOT_W-1:0];
  assign evict = (job_r.action == swrl_pkg::ACT_ACQUIRE) && (cnt_r != '0) && (age > win);
  assign allow = (job_r.action == swrl_pkg::ACT_ACQUIRE) && !evict && (cnt_r < limit);
  assign out_load = (state_r == S_WAIT) && (!ov_r || out_ready);

  always_comb begin
    stamp_we = 1'b0;
    stamp_addr = {flow, head_r};
    if (state_r == S_LOAD) begin
      stamp_addr = {flow, meta_rd.head};
    end else if (state_r == S_EVAL && allow) begin
      stamp_we = 1'b1;
      stamp_addr = {flow, pos};
    end
  end

  // After reset the ring memory is cleared one flow per cycle.
  always_comb begin
    meta_we = 1'b0;
    meta_addr = flow;
    meta_wdata.head = head_r;
    meta_wdata.count = allow ? cnt_r + 1'b1 : cnt_r;
    if (state_r == S_CLEAR) begin
      meta_we = 1'b1;
      meta_addr = clr_r;
      meta_wdata = '0;
    end else if (state_r == S_EVAL && !evict && job_r.action == swrl_pkg::ACT_ACQUIRE) begin
      meta_we = 1'b1;
    end
  end

  swrl_ram #(.Width(32), .Depth(swrl_pkg::NUM_FLOWS * swrl_pkg::MAX_SLOTS)) u_ram (
    .clk(clk), .we(stamp_we), .addr(stamp_addr), .wdata(job_r.now), .rdata(stamp_rd)
  );

  swrl_ram #(.Width($bits(swrl_pkg::ring_t)), .Depth(swrl_pkg::NUM_FLOWS)) u_ring_ram (
    .clk(clk), .we(meta_we), .addr(meta_addr), .wdata(meta_wdata), .rdata(meta_rd)
  );

  assign job_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == swrl_pkg::FLOW_W'(swrl_pkg::NUM_FLOWS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (job_valid) state_nxt = job.no_rule ? S_WAIT : S_META;
      S_META: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_EVAL;
      S_READ: state_nxt = S_EVAL;
      // Evict one stale stamp per pass; reread the new head after it.
      S_EVAL: state_nxt = evict ? S_READ : S_WAIT;
      S_WAIT: if (!ov_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      ov_r <= 1'b0;
      maxr_r[0] <= 8'd5;   maxr_r[1] <= 8'd10;
      maxr_r[2] <= 8'd30;  maxr_r[3] <= 8'd100;
      win_r[0] <= 32'd60;  win_r[1] <= 32'd60;
      win_r[2] <= 32'd60;  win_r[3] <= 32'd3600;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_load) ov_r <= 1'b1;
      else if (out_valid && out_ready) ov_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index < swrl_pkg::REG_WINDOW_0) begin
          maxr_r[cfg_index[1:0]] <= cfg_data[7:0];
        end else begin
          win_r[cfg_index[1:0]] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && job_valid) begin
      job_r <= job;
      res_w_r.allowed <= job.no_rule && job.action == swrl_pkg::ACT_ACQUIRE;
      res_w_r.retry_after <= '0;
    end
    if (state_r == S_LOAD) begin
      head_r <= meta_rd.head;
      cnt_r <= meta_rd.count;
    end
    if (state_r == S_EVAL) begin
      if (evict) begin
        head_r <= head_r + 1'b1;
        cnt_r <= cnt_r - 1'b1;
      end
      res_w_r.allowed <= allow;
      res_w_r.retry_after <= (job_r.action == swrl_pkg::ACT_QUERY && cnt_r != '0 &&
                              age < win) ? win - age : 32'd0;
    end
    if (out_load) res_r <= res_w_r;
  end
endmodule

>>> hdl/sliding_window_rate_limiter_core.sv
// Top level of the sliding-window-log rate limiter.
// Depends on swrl_pkg, swrl_front and swrl_back.
//
// Input transactions (in_valid/in_ready) carry an action, a group, a key and
// the current time; each gives one result transaction (out_valid/out_ready)
// with allowed and retry_after. A two-entry queue in front lets items be
// taken while the back end works. The back end reads the flow's ring head and
// count from a ring memory, then the oldest stamp from the stamp memory; both
// have a registered read. The back end takes one item at a time through the
// states IDLE, META, LOAD, EVAL and WAIT; each stale stamp evicted adds a pass
// through READ and EVAL. Items with no rule skip both memories and go from IDLE
// straight to WAIT. After reset the back end clears the ring memory, one flow
// per cycle, and loads the default limits and windows; the stamp memory is
// not cleared. Up to two items are queued during that pass.
// When the receiver stalls, the result is held in the output register and the
// back end finishes the next item and waits; the queue fills and then in_ready
// drops. Configuration writes are taken any cycle and should be made only
// while the block is idle.
module sliding_window_rate_limiter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swrl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output swrl_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  logic job_valid, job_ready;
  swrl_pkg::job_t job;

  swrl_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .job_valid, .job_ready, .job
  );

  swrl_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .out_data
  );
endmodule

>>> hdl/swrl_checker.sv
// Port-level checker for the rate limiter core, bound to the top level.
// Depends on swrl_pkg.
module swrl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input swrl_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input swrl_pkg::out_item_t out_data
);
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
  a_query_deny: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.allowed && out_data.retry_after != 32'd0))
    else $error("allowed result with nonzero retry");
endmodule

bind sliding_window_rate_limiter_core swrl_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
);

>>> tb/sliding_window_rate_limiter_core_tb.sv
// Self-checking testbench for the sliding-window-log rate limiter core.
// Depends on swrl_pkg and the sliding_window_rate_limiter_core RTL; it predicts every
// result from its own model of the stamp rings and checks results in order.
module sliding_window_rate_limiter_core_tb;

  localparam int NumGroups = swrl_pkg::NUM_GROUPS;
  localparam int NumKeys = swrl_pkg::NUM_KEYS;
  localparam int MaxSlots = swrl_pkg::MAX_SLOTS;
  localparam logic [2:0] GroupNoRule = 3'd4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  swrl_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  swrl_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sliding_window_rate_limiter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow state of the limiter.
  logic [7:0]  limit_reg [NumGroups];
  logic [31:0] window_reg [NumGroups];
  logic [31:0] stamps [NumGroups*NumKeys][MaxSlots];
  int unsigned oldest [NumGroups*NumKeys];
  int unsigned live [NumGroups*NumKeys];

  swrl_pkg::in_item_t  pending_items[$];
  swrl_pkg::out_item_t expected_results[$];
  int errors = 0;
  bit idle_en = 1'b1;
  bit long_hold_req = 1'b0;
  int send_gap = 0;
  int hold_cnt = 0;
  logic [31:0] clock_now = 32'd0;

  function automatic swrl_pkg::out_item_t limiter_decide(swrl_pkg::in_item_t it);
    swrl_pkg::out_item_t r;
    int unsigned f, lim, pos;
    logic [31:0] win, age;
    r = '0;
    if (it.group >= NumGroups) begin
      r.allowed = (it.action == swrl_pkg::ACT_ACQUIRE);
      return r;
    end
    f = it.group * NumKeys + it.key_id;
    win = window_reg[it.group];
    if (it.action == swrl_pkg::ACT_ACQUIRE) begin
      while (live[f] > 0 && (it.now - stamps[f][oldest[f]]) > win) begin
        oldest[f] = (oldest[f] + 1) % MaxSlots;
        live[f]--;
      end
      lim = limit_reg[it.group];
      if (lim > MaxSlots) lim = MaxSlots;
      if (live[f] < lim) begin
        pos = (oldest[f] + live[f]) % MaxSlots;
        stamps[f][pos] = it.now;
        live[f]++;
        r.allowed = 1'b1;
      end
    end else if (live[f] > 0) begin
      age = it.now - stamps[f][oldest[f]];
      if (age < win) r.retry_after = win - age;
    end
    return r;
  endfunction

  task automatic add_item(input swrl_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Driver: offers queued items and predicts each accepted transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(), limiter_decide(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items[0];
          pending_items.delete(0);
          in_valid <= 1'b1;
          if (idle_en && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver: checks results in order and stalls at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          swrl_pkg::out_item_t e;
          e = expected_results[0];
          expected_results.delete(0);
          if (out_data.allowed !== e.allowed) begin
            $error("allowed: expected %0d, got %0d", e.allowed, out_data.allowed);
            errors++;
          end
          if (out_data.retry_after !== e.retry_after) begin
            $error("retry_after: expected %0d, got %0d", e.retry_after, out_data.retry_after);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cnt = 300;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < swrl_pkg::REG_WINDOW_0) limit_reg[idx] = val[7:0];
    else window_reg[idx - swrl_pkg::REG_WINDOW_0] = val;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || send_gap > 0 ||
           expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic swrl_pkg::in_item_t make_item(logic act, logic [2:0] grp,
                                                   logic [3:0] key, logic [31:0] t);
    swrl_pkg::in_item_t it;
    it.action = act;
    it.group = grp;
    it.key_id = key;
    it.now = t;
    return it;
  endfunction

  function automatic swrl_pkg::in_item_t random_item();
    int r;
    logic [2:0] grp;
    logic [3:0] key;
    r = $urandom_range(0, 99);
    if (r < 2) clock_now = clock_now + $urandom();
    else if (r < 50) clock_now = clock_now + $urandom_range(0, 4);
    r = $urandom_range(0, 19);
    grp = (r < 2) ? 3'($urandom_range(4, 7)) : 3'(r % NumGroups);
    key = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
    return make_item(($urandom_range(0, 3) == 0) ? swrl_pkg::ACT_QUERY : swrl_pkg::ACT_ACQUIRE,
                     grp, key, clock_now);
  endfunction

  initial begin
    #50_000_000;
    $display("sliding_window_rate_limiter_core_tb: FAIL");
    $finish;
  end

  initial begin
    limit_reg[0] = 8'd5;    limit_reg[1] = 8'd10;
    limit_reg[2] = 8'd30;   limit_reg[3] = 8'd100;
    window_reg[0] = 32'd60; window_reg[1] = 32'd60;
    window_reg[2] = 32'd60; window_reg[3] = 32'd3600;
    for (int f = 0; f < NumGroups*NumKeys; f++) begin
      oldest[f] = 0;
      live[f] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: defaults, no-rule groups, limit reached, empty and stale queries.
    add_item(make_item(swrl_pkg::ACT_QUERY, 3'd0, 4'd0, 32'd0));
    add_item(make_item(swrl_pkg::ACT_ACQUIRE, GroupNoRule, 4'd15, 32'd0));
    add_item(make_item(swrl_pkg::ACT_QUERY, GroupNoRule, 4'd3, 32'd0));
    add_item(make_item(swrl_pkg::ACT_ACQUIRE, 3'd7, 4'd9, 32'hFFFF_FFFF));
    add_item(make_item(swrl_pkg::ACT_QUERY, 3'd5, 4'd6, 32'hFFFF_FFFF));
    for (int i = 0; i < 6; i++)
      add_item(make_item(swrl_pkg::ACT_ACQUIRE, 3'd0, 4'd15, 32'd10));
    add_item(make_item(swrl_pkg::ACT_QUERY, 3'd0, 4'd15, 32'd30));
    add_item(make_item(swrl_pkg::ACT_QUERY, 3'd0, 4'd15, 32'd70));
    add_item(make_item(swrl_pkg::ACT_QUERY, 3'd0, 4'd15, 32'd200));
    add_item(make_item(swrl_pkg::ACT_ACQUIRE, 3'd0, 4'd15, 32'd71));
    add_item(make_item(swrl_pkg::ACT_ACQUIRE, 3'd3, 4'd0, 32'hFFFF_FFF0));
    add_item(make_item(swrl_pkg::ACT_QUERY, 3'd3, 4'd0, 32'd5));
    add_item(make_item(swrl_pkg::ACT_ACQUIRE, 3'd1, 4'd7, 32'd100));
    add_item(make_item(swrl_pkg::ACT_ACQUIRE, 3'd2, 4'd8, 32'd100));
    wait_drained();

    // Full ring: a limit of 128 with an endless window, then mass eviction.
    for (int g = 0; g < NumGroups; g++) write_reg(3'(swrl_pkg::REG_MAX_REQ_0 + g), 32'd128);
    write_reg(swrl_pkg::REG_WINDOW_0, 32'hFFFF_FFFF);
    end_writes();
    for (int i = 0; i < 130; i++)
      add_item(make_item(swrl_pkg::ACT_ACQUIRE, 3'd0, 4'd1, 32'd1000 + i / 8));
    add_item(make_item(swrl_pkg::ACT_QUERY, 3'd0, 4'd1, 32'd1000));
    wait_drained();
    write_reg(swrl_pkg::REG_WINDOW_0, 32'd0);
    end_writes();
    add_item(make_item(swrl_pkg::ACT_QUERY, 3'd0, 4'd1, 32'd2000));
    add_item(make_item(swrl_pkg::ACT_ACQUIRE, 3'd0, 4'd1, 32'd2000));
    add_item(make_item(swrl_pkg::ACT_ACQUIRE, 3'd0, 4'd1, 32'd2000));
    add_item(make_item(swrl_pkg::ACT_QUERY, 3'd0, 4'd1, 32'd2000));
    wait_drained();
    clock_now = 32'd2000;

    // Random phases, each with fresh limits and windows.
    for (int ph = 0; ph < 8; ph++) begin
      for (int g = 0; g < NumGroups; g++) begin
        int r;
        r = $urandom_range(0, 9);
        write_reg(3'(swrl_pkg::REG_MAX_REQ_0 + g), (r == 0) ? 32'd0 : (r == 1) ? 32'd128 :
                  32'($urandom_range(1, 8)));
        r = $urandom_range(0, 9);
        write_reg(3'(swrl_pkg::REG_WINDOW_0 + g), (r == 0) ? 32'd0 :
                  (r == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 25)));
      end
      end_writes();
      if (ph == 4) clock_now = 32'hFFFF_FF80;
      if (ph == 7) idle_en = 1'b0;
      for (int i = 0; i < 170; i++) add_item(random_item());
      if (ph == 2) long_hold_req = 1'b1;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("sliding_window_rate_limiter_core_tb: PASS");
    else $display("sliding_window_rate_limiter_core_tb: FAIL");
    $finish;
  end

endmodule
